// ----- design/mrc_pkg.sv -----
package mrc_pkg;

    typedef struct packed {
        logic        kind;
        logic [13:0] load_index;
        logic [31:0] load_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pc_now;
        logic [4:0]  wrote_reg;
        logic [31:0] wrote_value;
        logic        halted;
        logic        good_trap;
        logic        illegal;
    } out_item_t;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [2:0] F3_BYTE  = 3'd0;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EXEC = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ----- design/mrc_ram.sv -----
module mrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/mrc_front.sv -----
module mrc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mrc_pkg::in_item_t in_item,
    output logic              q_valid,
    input  logic              q_take,
    output mrc_pkg::in_item_t q_item
);

    import mrc_pkg::*;

    in_item_t    buf_reg [QUEUE_DEPTH];
    logic        rd_ptr_reg, wr_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'(QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = buf_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- design/mrc_back.sv -----
module mrc_back #(
    parameter int MEM_WORDS = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    input  logic               q_valid,
    output logic               q_take,
    input  mrc_pkg::in_item_t  q_item,
    output logic               res_valid,
    input  logic               res_take,
    output mrc_pkg::out_item_t res_item
);

    import mrc_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_MEM   = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] pc_reg;
    logic [31:0] rf_reg [32];
    logic        halt_reg, good_reg;
    logic        res_valid_reg;
    out_item_t   res_reg;
    logic [31:0] inst_reg;
    logic [31:0] addr_reg;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [31:0]    ram_wdata, ram_rdata;

    mrc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, immi, imms, ld_addr, st_addr;
    logic        out_free;
    logic [4:0]  sh;

    assign op      = inst_reg[6:0];
    assign f3      = inst_reg[14:12];
    assign rd      = inst_reg[11:7];
    assign a       = rf_reg[inst_reg[19:15]];
    assign b       = rf_reg[inst_reg[24:20]];
    assign immi    = {{20{inst_reg[31]}}, inst_reg[31:20]};
    assign imms    = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign ld_addr = a + immi;
    assign st_addr = a + imms;
    assign sh      = {addr_reg[1:0], 3'b000};
    assign out_free = !res_valid_reg || res_take;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;
    assign q_take    = (state_reg == ST_IDLE) && q_valid && out_free && !cfg_valid;

    out_item_t   emit;
    logic        emit_en;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    logic [31:0] pc_next;
    logic        halt_next, good_next;
    logic [31:0] inst_next, addr_next;

    always_comb
    begin
        state_next = state_reg;
        emit_en    = 1'b0;
        rf_we      = 1'b0;
        rf_wa      = rd;
        rf_wd      = 32'd0;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        good_next  = good_reg;
        inst_next  = inst_reg;
        addr_next  = addr_reg;
        ram_we     = 1'b0;
        ram_waddr  = AW'(q_item.load_index);
        ram_wdata  = q_item.load_data;
        ram_raddr  = pc_reg[AW+1:2];
        emit.pc_now      = pc_reg;
        emit.wrote_reg   = 5'd0;
        emit.wrote_value = 32'd0;
        emit.halted      = halt_reg;
        emit.good_trap   = good_reg;
        emit.illegal     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_take)
                begin
                    if (halt_reg || q_item.kind == KIND_LOAD)
                    begin
                        ram_we  = !halt_reg;
                        emit_en = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                inst_next  = ram_rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                pc_next    = pc_reg + 32'd4;
                state_next = ST_IDLE;
                emit_en    = 1'b1;
                case (op)
                    OP_REG:
                    begin
                        rf_we = 1'b1;
                        rf_wd = a + b;
                    end
                    OP_IMM:
                    begin
                        rf_we = 1'b1;
                        rf_wd = ld_addr;
                    end
                    OP_LUI:
                    begin
                        rf_we = 1'b1;
                        rf_wd = {inst_reg[31:12], 12'd0};
                    end
                    OP_LOAD, OP_STORE:
                    begin
                        addr_next = (op == OP_LOAD) ? ld_addr : st_addr;
                        ram_raddr = addr_next[AW+1:2];
                        if ((op == OP_LOAD && (f3 == F3_WORD || f3 == F3_BYTEU)) ||
                            (op == OP_STORE && (f3 == F3_WORD || f3 == F3_BYTE)))
                        begin
                            pc_next    = pc_reg;
                            emit_en    = 1'b0;
                            state_next = ST_MEM;
                        end
                    end
                    OP_JALR:
                    begin
                        rf_we   = 1'b1;
                        rf_wd   = pc_reg + 32'd4;
                        pc_next = {ld_addr[31:1], 1'b0};
                    end
                    OP_SYSTEM:
                    begin
                        halt_next = 1'b1;
                        good_next = (rf_reg[10] == 32'd0);
                        pc_next   = pc_reg;
                    end
                    default:
                    begin
                        emit.illegal = 1'b1;
                    end
                endcase
            end
            ST_MEM:
            begin
                pc_next    = pc_reg + 32'd4;
                state_next = ST_IDLE;
                emit_en    = 1'b1;
                ram_waddr  = addr_reg[AW+1:2];
                if (op == OP_LOAD)
                begin
                    rf_we = 1'b1;
                    rf_wd = (f3 == F3_WORD) ? ram_rdata : {24'd0, 8'(ram_rdata >> sh)};
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = (f3 == F3_WORD) ? b :
                                ((ram_rdata & ~(32'hFF << sh)) | ({24'd0, b[7:0]} << sh));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (rf_we && rd != 5'd0)
        begin
            emit.wrote_reg   = rd;
            emit.wrote_value = rf_wd;
        end
        emit.pc_now    = pc_next;
        emit.halted    = halt_next;
        emit.good_trap = good_next;
    end

    always_ff @(posedge clk)
    begin
        inst_reg <= inst_next;
        addr_reg <= addr_next;
        if (emit_en)
        begin
            res_reg <= emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= 32'd0;
            halt_reg      <= 1'b0;
            good_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 32; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            halt_reg  <= halt_next;
            good_reg  <= good_next;
            if (cfg_valid && cfg_ready)
            begin
                pc_reg <= cfg_data;
            end
            else
            begin
                pc_reg <= pc_next;
            end
            if (emit_en)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
            if (rf_we && rd != 5'd0)
            begin
                rf_reg[rd] <= rf_wd;
            end
        end
    end

endmodule

// ----- design/minimal_rv32_subset_core_top.sv -----
// Channel | Handshake            | Payload
// input   | push / full          | in_item  (kind, load_index, load_data)
// result  | pop / empty          | out_item (pc_now, wrote_reg, ...)
// config  | cfg_valid/cfg_ready  | cfg_data (start_pc)
// The back end writes a memory beat from its idle state; an instruction runs
// fetch and execute, plus mem for lw, lbu, sw, sb (one registered read port).
// Reset clears PC, registers and flags; memory holds garbage until written.
// A two-entry queue decouples input beats; a full result register stalls
// the back end until pop.
module minimal_rv32_subset_core_top #(
    parameter int MEM_WORDS = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mrc_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output mrc_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    import mrc_pkg::*;

    logic     q_valid, q_take, res_valid;
    in_item_t q_item;

    mrc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    mrc_back #(.MEM_WORDS(MEM_WORDS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .res_valid (res_valid),
        .res_take  (pop),
        .res_item  (out_item)
    );

    assign empty = !res_valid;

endmodule

// ----- design/mrc_checker.sv -----
module mrc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input mrc_pkg::out_item_t out_item
);

    import mrc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while stalled");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.halted) |-> !out_item.illegal)
        else $error("illegal reported while halted");

    a_good_needs_halt: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.good_trap) |-> out_item.halted)
        else $error("good trap without halt");

    a_x0: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.wrote_reg == 5'd0) |-> out_item.wrote_value == 32'd0)
        else $error("value reported without destination");

endmodule

bind minimal_rv32_subset_core_top mrc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
